### hdl/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg
// shared constants and types for the two-heap running median core
// ----------------------------------------------------------------------------
`default_nettype none

package rmth_pkg;

   localparam int HALF_CAPACITY = 512;
   localparam int SAMPLE_WIDTH  = 32;
   localparam int ADDR_WIDTH    = $clog2(HALF_CAPACITY);
   localparam int COUNT_WIDTH   = ADDR_WIDTH + 1;
   localparam int CHILD_WIDTH   = COUNT_WIDTH + 1;
   localparam int TOTAL_WIDTH   = COUNT_WIDTH + 1;
   localparam int MEDIAN_WIDTH  = 33;
   localparam int SUM_WIDTH     = 11;
   localparam int REQ_WIDTH     = 32;
   localparam int RSP_WIDTH     = 48;

   typedef logic signed [SAMPLE_WIDTH-1:0] sample_type;
   typedef logic [ADDR_WIDTH-1:0]           addr_type;
   typedef logic [COUNT_WIDTH-1:0]          count_type;
   typedef logic [CHILD_WIDTH-1:0]          child_type;

   // heap operation in progress for the current sample
   typedef enum logic [1:0] {
      PH_POP,
      PH_PUSH_T,
      PH_PUSH_X
   } phase_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLAN,
      ST_POP_READ,
      ST_POP_LAST,
      ST_DN_LEFT,
      ST_DN_RIGHT,
      ST_DN_CMP,
      ST_PUSH,
      ST_UP_READ,
      ST_UP_CMP,
      ST_TOPS_READ,
      ST_TOPS_WAIT,
      ST_RESULT
   } state_type;

   // is a "before" b in heap order
   function automatic logic heap_before(input logic is_max, input sample_type a,
                                        input sample_type b);
      heap_before = is_max ? (a > b) : (a < b);
   endfunction

endpackage

`default_nettype wire

### hdl/rmth_ram.sv
// ----------------------------------------------------------------------------
// rmth_ram
// generic single-port ram with registered read
// ----------------------------------------------------------------------------
`default_nettype none

module rmth_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 512
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[addr] <= wr_data;
      end
      rd_data <= mem[addr];
   end

endmodule

`default_nettype wire

### hdl/running_median_two_heaps_core.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_core
// running median of a signed stream kept in a max-heap and a min-heap
// ----------------------------------------------------------------------------
// Each req beat carries one 32-bit signed sample; each sample gives exactly
// one rsp beat with twice the running median (33-bit signed, exact at the
// half step), the number of samples held, and a full flag when the sample
// was dropped because both heaps (512 entries each) are full. The heaps live
// in two single-port rams with registered read and are walked by one
// sequencer that moves a hole through the heap: sift-down reads the left
// child, reads the right child, then compares and writes at each level;
// sift-up reads the parent, then compares and writes at each level. A sample
// runs through plan, then, when a top moves across, the pop read and
// last-entry fetch and the sift-down, then a push with sift-up (two pushes
// when a top moves), then the top read and the result step; a dropped
// sample goes straight from plan to the top read. The core returns to idle
// before it takes the next sample. No item is accepted while one is in
// progress; a finished result waits in the rsp register while the next
// sample runs, and the sequencer only waits at its result step if that
// beat is still not taken. Heap contents need no clearing after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module running_median_two_heaps_core (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_tvalid,
   output logic                                req_tready,
   input  wire logic [rmth_pkg::REQ_WIDTH-1:0] req_tdata,  // sample[31:0]
   output logic                                rsp_tvalid,
   input  wire logic                           rsp_tready,
   // median_doubled[32:0], sample_count[43:33], store_full[44], zero pad
   output logic      [rmth_pkg::RSP_WIDTH-1:0] rsp_tdata
);

   import rmth_pkg::*;

   state_type state_ff, state_in;
   state_type after_op;             // where to go when a heap op finishes

   // heap side selects: 1 = lower (max) heap
   count_type  lcnt_ff, lcnt_in, ucnt_ff, ucnt_in;
   sample_type x_ff, x_in;          // incoming sample
   sample_type t_ff, t_in;          // popped top to move across
   sample_type v_ff, v_in;          // value being sifted (fills the hole last)
   sample_type best_ff, best_in;    // sift-down: best of value and left child
   addr_type   i_ff, i_in;          // current hole position
   addr_type   c_ff, c_in;          // chosen child / parent address
   logic       side_ff, side_in;    // heap currently worked on
   phase_type  ph_ff, ph_in;
   logic       full_ff, full_in;
   sample_type ltop_ff, ltop_in, utop_ff, utop_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [RSP_WIDTH-1:0]  rsp_data_ff, rsp_data_in;

   // ram ports
   logic       l_we, u_we;
   addr_type   l_addr, u_addr;
   sample_type l_wd, u_wd, l_rd, u_rd;

   rmth_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HALF_CAPACITY)) u_lower_ram (
      .clock(clock), .wr_en(l_we), .addr(l_addr), .wr_data(l_wd), .rd_data(l_rd)
   );
   rmth_ram #(.WIDTH(SAMPLE_WIDTH), .DEPTH(HALF_CAPACITY)) u_upper_ram (
      .clock(clock), .wr_en(u_we), .addr(u_addr), .wr_data(u_wd), .rd_data(u_rd)
   );

   // selected-side helpers
   sample_type rd_sel;
   count_type  cnt_sel;
   logic       wr_en;
   addr_type   rw_addr;
   sample_type wr_data;
   child_type  lchild, rchild;
   logic       left_ok, right_ok, dn_right_win, dn_move, up_swap;
   logic       at_capacity, plan_move, plan_side, rsp_free;
   logic signed [MEDIAN_WIDTH-1:0] med;
   logic [TOTAL_WIDTH-1:0] total;

   assign rd_sel  = side_ff ? l_rd : u_rd;
   assign cnt_sel = side_ff ? lcnt_ff : ucnt_ff;
   assign lchild  = {1'b0, i_ff, 1'b1};
   assign rchild  = lchild + child_type'(1);
   assign left_ok  = lchild < child_type'(cnt_sel);
   assign right_ok = rchild < child_type'(cnt_sel);

   // sift-down: right child wins over the best so far, or left already won
   assign dn_right_win = right_ok && heap_before(side_ff, rd_sel, best_ff);
   assign dn_move      = dn_right_win || (c_ff != i_ff);
   // sift-up: value goes above its parent
   assign up_swap      = heap_before(side_ff, v_ff, rd_sel);

   assign l_we   = wr_en && side_ff;
   assign u_we   = wr_en && !side_ff;
   // both rams see address 0 during the top read
   assign l_addr = side_ff ? rw_addr : '0;
   assign u_addr = !side_ff ? rw_addr : '0;
   assign l_wd   = wr_data;
   assign u_wd   = wr_data;

   assign total       = TOTAL_WIDTH'(lcnt_ff) + TOTAL_WIDTH'(ucnt_ff);
   assign at_capacity = total >= TOTAL_WIDTH'(2 * HALF_CAPACITY);
   assign rsp_free    = !rsp_valid_ff || rsp_tready;

   // insert plan: a top moves across when the sample lands on the larger side
   assign plan_move = (lcnt_ff > ucnt_ff) ? (x_ff < ltop_ff)
                    : (lcnt_ff < ucnt_ff) ? (x_ff > utop_ff) : 1'b0;
   // side to pop from when moving, else side to push onto
   assign plan_side = (lcnt_ff == ucnt_ff) ? ((lcnt_ff == '0) || (x_ff < ltop_ff))
                    : (lcnt_ff > ucnt_ff) ? plan_move : !plan_move;

   assign after_op = (ph_ff == PH_PUSH_X) ? ST_TOPS_READ : ST_PUSH;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE:      if (req_tvalid) state_in = ST_PLAN;
         ST_PLAN:      state_in = at_capacity ? ST_TOPS_READ
                                 : (plan_move ? ST_POP_READ : ST_PUSH);
         ST_POP_READ:  state_in = ST_POP_LAST;
         ST_POP_LAST:  state_in = ST_DN_LEFT;
         ST_DN_LEFT:   state_in = left_ok ? ST_DN_RIGHT : after_op;
         ST_DN_RIGHT:  state_in = ST_DN_CMP;
         ST_DN_CMP:    state_in = dn_move ? ST_DN_LEFT : after_op;
         ST_PUSH:      state_in = ST_UP_READ;
         ST_UP_READ:   state_in = (i_ff == '0) ? after_op : ST_UP_CMP;
         ST_UP_CMP:    state_in = up_swap ? ST_UP_READ : after_op;
         ST_TOPS_READ: state_in = ST_TOPS_WAIT;
         ST_TOPS_WAIT: state_in = ST_RESULT;
         ST_RESULT:    if (rsp_free) state_in = ST_IDLE;
         default:      state_in = ST_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      lcnt_in = lcnt_ff; ucnt_in = ucnt_ff; x_in = x_ff; t_in = t_ff;
      v_in = v_ff; best_in = best_ff; i_in = i_ff; c_in = c_ff;
      side_in = side_ff; ph_in = ph_ff; full_in = full_ff;
      ltop_in = ltop_ff; utop_in = utop_ff;
      wr_en = 1'b0; rw_addr = '0; wr_data = v_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in = rsp_data_ff;
      med = '0;
      req_tready = (state_ff == ST_IDLE);

      case (state_ff)
         ST_IDLE: begin
            x_in = sample_type'(req_tdata[SAMPLE_WIDTH-1:0]);
         end
         ST_PLAN: begin
            full_in = at_capacity;
            side_in = plan_side;
            ph_in   = plan_move ? PH_POP : PH_PUSH_X;
            v_in    = x_ff;
         end
         ST_POP_READ: begin
            // top already held in ltop/utop, fetch the last entry
            t_in = side_ff ? ltop_ff : utop_ff;
            rw_addr = addr_type'(cnt_sel - count_type'(1));
            if (side_ff) lcnt_in = lcnt_ff - count_type'(1);
            else         ucnt_in = ucnt_ff - count_type'(1);
         end
         ST_POP_LAST: begin
            v_in = rd_sel;
            i_in = '0;
         end
         ST_DN_LEFT: begin
            if (left_ok) begin
               rw_addr = addr_type'(lchild);
            end else begin
               wr_en = 1'b1; rw_addr = i_ff; wr_data = v_ff;
            end
         end
         ST_DN_RIGHT: begin
            // left child data is back, right child read goes out
            best_in = v_ff;
            c_in    = i_ff;
            if (heap_before(side_ff, rd_sel, v_ff)) begin
               best_in = rd_sel;
               c_in    = addr_type'(lchild);
            end
            rw_addr = addr_type'(rchild);
         end
         ST_DN_CMP: begin
            wr_en = 1'b1; rw_addr = i_ff; wr_data = v_ff;
            if (dn_move) begin
               wr_data = dn_right_win ? rd_sel : best_ff;
               i_in    = dn_right_win ? addr_type'(rchild) : c_ff;
            end
         end
         ST_PUSH: begin
            case (ph_ff)
               PH_POP: begin
                  side_in = !side_ff; v_in = t_ff; ph_in = PH_PUSH_T;
               end
               PH_PUSH_T: begin
                  side_in = !side_ff; v_in = x_ff; ph_in = PH_PUSH_X;
               end
               default: ;
            endcase
            i_in = addr_type'(side_in ? lcnt_ff : ucnt_ff);
            if (side_in) lcnt_in = lcnt_ff + count_type'(1);
            else         ucnt_in = ucnt_ff + count_type'(1);
         end
         ST_UP_READ: begin
            if (i_ff == '0) begin
               wr_en = 1'b1; rw_addr = '0; wr_data = v_ff;
            end else begin
               c_in = addr_type'((i_ff - addr_type'(1)) >> 1);
               rw_addr = c_in;
            end
         end
         ST_UP_CMP: begin
            wr_en = 1'b1; rw_addr = i_ff; wr_data = v_ff;
            if (up_swap) begin
               wr_data = rd_sel;
               i_in = c_ff;
            end
         end
         ST_TOPS_READ: begin
            rw_addr = '0;
         end
         ST_TOPS_WAIT: begin
            ltop_in = l_rd; utop_in = u_rd;
         end
         ST_RESULT: begin
            if (lcnt_ff == ucnt_ff) begin
               if (lcnt_ff != '0)
                  med = MEDIAN_WIDTH'(ltop_ff) + MEDIAN_WIDTH'(utop_ff);
            end else if (lcnt_ff > ucnt_ff) begin
               med = MEDIAN_WIDTH'(ltop_ff) <<< 1;
            end else begin
               med = MEDIAN_WIDTH'(utop_ff) <<< 1;
            end
            if (rsp_free) begin
               rsp_valid_in = 1'b1;
               rsp_data_in = '0;
               rsp_data_in[MEDIAN_WIDTH-1:0] = med;
               rsp_data_in[MEDIAN_WIDTH +: SUM_WIDTH] = SUM_WIDTH'(total);
               rsp_data_in[MEDIAN_WIDTH+SUM_WIDTH] = full_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         lcnt_ff <= '0;
         ucnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         lcnt_ff <= lcnt_in;
         ucnt_ff <= ucnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      x_ff <= x_in; t_ff <= t_in; v_ff <= v_in; best_ff <= best_in;
      i_ff <= i_in; c_ff <= c_in; side_ff <= side_in;
      ph_ff <= ph_in; full_ff <= full_in;
      ltop_ff <= ltop_in; utop_ff <= utop_in; rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

`ifndef SYNTH
   a_balance: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> (lcnt_ff == ucnt_ff
                               || lcnt_ff == ucnt_ff + count_type'(1)
                               || ucnt_ff == lcnt_ff + count_type'(1)))
      else $error("heap sizes out of balance");
   a_bound: assert property (@(posedge clock) disable iff (reset)
      lcnt_ff <= count_type'(HALF_CAPACITY) && ucnt_ff <= count_type'(HALF_CAPACITY))
      else $error("heap count overflow");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("rsp beat dropped");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != ST_IDLE |-> !req_tready)
      else $error("accept while busy");
`endif

endmodule

`default_nettype wire

### tb/tb_running_median_two_heaps_core.sv
// ----------------------------------------------------------------------------
// tb_running_median_two_heaps_core
// self-checking bench for the two-heap running median core
// ----------------------------------------------------------------------------
// Each sample beat is fed to a local two-heap model that predicts the doubled
// median, sample count and full flag; a monitor compares every rsp beat with
// the oldest prediction. Stimulus runs directed extremes and ties, then
// random phases with sender gaps and receiver stalls, then fills the store
// past capacity to exercise the dropped-sample path.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps
`default_nettype none

module tb_running_median_two_heaps_core;
   import rmth_pkg::*;

   localparam int WATCHDOG_LIMIT = 20000;
   localparam int TAIL_CYCLES    = 100;

   typedef struct packed {
      logic signed [MEDIAN_WIDTH-1:0] median_doubled;
      logic [SUM_WIDTH-1:0]           sample_count;
      logic                           store_full;
   } median_result_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [REQ_WIDTH-1:0] req_tdata = '0;   // sample[31:0]
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   // median_doubled[32:0], sample_count[43:33], store_full[44], zero pad
   logic [RSP_WIDTH-1:0] rsp_tdata;

   // model state: heaps as sign-extended 64-bit values
   longint            low_heap[HALF_CAPACITY];
   longint            high_heap[HALF_CAPACITY];
   int                low_n, high_n;
   median_result_type pending_medians[$];

   int  mismatch_count = 0;
   int  idle_cycles    = 0;
   int  send_idle_pct  = 0;
   int  stall_pct      = 0;
   bit  timed_out      = 0;

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   running_median_two_heaps_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   // heap order: max-heap for the lower half, min-heap for the upper half
   function automatic bit heap_first(bit is_max, longint a, longint b);
      return is_max ? (a > b) : (a < b);
   endfunction

   task automatic heap_insert(bit is_max, longint v);
      int     i, p;
      longint t;
      if (is_max) begin
         i = low_n; low_heap[i] = v; low_n++;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (!heap_first(1, low_heap[i], low_heap[p])) break;
            t = low_heap[i]; low_heap[i] = low_heap[p]; low_heap[p] = t;
            i = p;
         end
      end else begin
         i = high_n; high_heap[i] = v; high_n++;
         while (i > 0) begin
            p = (i - 1) / 2;
            if (!heap_first(0, high_heap[i], high_heap[p])) break;
            t = high_heap[i]; high_heap[i] = high_heap[p]; high_heap[p] = t;
            i = p;
         end
      end
   endtask

   task automatic heap_remove_top(bit is_max, output longint top);
      int     i, l, r, best, n;
      longint t;
      longint h[HALF_CAPACITY];
      if (is_max) begin
         h = low_heap; n = low_n;
      end else begin
         h = high_heap; n = high_n;
      end
      top = h[0];
      n--;
      h[0] = h[n];
      i = 0;
      forever begin
         l = 2 * i + 1; r = l + 1; best = i;
         if (l < n && heap_first(is_max, h[l], h[best])) best = l;
         if (r < n && heap_first(is_max, h[r], h[best])) best = r;
         if (best == i) break;
         t = h[i]; h[i] = h[best]; h[best] = t;
         i = best;
      end
      if (is_max) begin low_heap = h; low_n = n; end
      else begin high_heap = h; high_n = n; end
   endtask

   // predict the result of one accepted sample and update the model
   task automatic predict_median(logic [REQ_WIDTH-1:0] raw);
      longint            x, moved, med;
      median_result_type r;
      x = longint'(signed'(raw[SAMPLE_WIDTH-1:0]));
      r.store_full = 1'b0;
      if (low_n + high_n >= 2 * HALF_CAPACITY) begin
         r.store_full = 1'b1;
      end else if (low_n == high_n) begin
         if (low_n == 0 || x < low_heap[0]) heap_insert(1, x);
         else heap_insert(0, x);
      end else if (low_n > high_n) begin
         if (x >= low_heap[0]) begin
            heap_insert(0, x);
         end else begin
            heap_remove_top(1, moved);
            heap_insert(0, moved);
            heap_insert(1, x);
         end
      end else begin
         if (x <= high_heap[0]) begin
            heap_insert(1, x);
         end else begin
            heap_remove_top(0, moved);
            heap_insert(1, moved);
            heap_insert(0, x);
         end
      end
      med = 0;
      if (low_n == high_n) begin
         if (low_n > 0) med = low_heap[0] + high_heap[0];
      end else if (low_n > high_n) begin
         med = 2 * low_heap[0];
      end else begin
         med = 2 * high_heap[0];
      end
      r.median_doubled = med[MEDIAN_WIDTH-1:0];
      r.sample_count   = SUM_WIDTH'(low_n + high_n);
      pending_medians.push_back(r);
   endtask

   // send one sample beat, with random sender gaps; valid stays up after
   // the beat until the next one or an idle cycle replaces it
   task automatic send_sample(logic [REQ_WIDTH-1:0] value);
      while ($urandom_range(99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_median(value);
      @(negedge clock);
   endtask

   // receiver stall pattern, changed at the falling edge
   always @(negedge clock) begin
      if (reset) rsp_tready <= 1'b0;
      else rsp_tready <= ($urandom_range(99) >= stall_pct);
   end

   // result checker and watchdog
   always @(posedge clock) begin
      median_result_type want, got;
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (rsp_tvalid && rsp_tready) begin
            got.median_doubled = rsp_tdata[32:0];
            got.sample_count   = rsp_tdata[43:33];
            got.store_full     = rsp_tdata[44];
            if (pending_medians.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected rsp beat: %h", rsp_tdata);
            end else begin
               want = pending_medians.pop_front();
               if (got != want) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch: expected med=%0d cnt=%0d full=%0b,",
                               " got med=%0d cnt=%0d full=%0b"},
                              want.median_doubled, want.sample_count, want.store_full,
                              got.median_doubled, got.sample_count, got.store_full);
               end
            end
         end
         if (idle_cycles >= WATCHDOG_LIMIT) timed_out = 1;
      end
   end

   task automatic set_idling(int send_pct, int stall);
      send_idle_pct = send_pct;
      stall_pct     = stall;
   endtask

   // extremes, ties on every side and wide values
   task automatic test_directed();
      logic [REQ_WIDTH-1:0] vals[$];
      vals = '{32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
               32'h0, 32'h0, 32'h0, 32'hFFFF_FFFF, 32'h1, 32'h1,
               32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000,
               32'h5555_5555, 32'hAAAA_AAAA, 32'h0000_0005, 32'h0000_0005,
               32'h0000_0005, 32'hFFFF_FFFB, 32'h0000_0005};
      set_idling(0, 0);
      foreach (vals[i]) send_sample(vals[i]);
   endtask

   // random samples, mostly from a narrow range so ties and moves are common
   task automatic test_random(int n, int send_pct, int stall);
      logic [REQ_WIDTH-1:0] v;
      set_idling(send_pct, stall);
      repeat (n) begin
         case ($urandom_range(3))
            0:       v = $urandom;
            1:       v = REQ_WIDTH'($signed($urandom_range(40)) - 20);
            2:       v = $urandom_range(1) ? 32'h7FFF_FFF0 + $urandom_range(15)
                                           : 32'h8000_0000 + $urandom_range(15);
            default: v = REQ_WIDTH'($signed($urandom_range(2000)) - 1000);
         endcase
         send_sample(v);
      end
   endtask

   // fill past capacity so the dropped-sample path is exercised
   task automatic test_store_full();
      set_idling(0, 28);
      while (low_n + high_n < 2 * HALF_CAPACITY) send_sample($urandom);
      repeat (480) send_sample($urandom);
   endtask

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      fork
         begin
            test_directed();
            test_random(150, 0, 0);
            test_random(200, 87, 0);
            test_random(200, 0, 87);
            test_random(200, 28, 28);
            test_random(200, 0, 0);
            test_store_full();
            set_idling(0, 0);
            req_tvalid <= 1'b0;
            while (pending_medians.size() != 0) @(posedge clock);
            repeat (TAIL_CYCLES) @(posedge clock);
         end
         begin
            wait (timed_out);
         end
      join_any
      if (timed_out || mismatch_count != 0 || pending_medians.size() != 0) begin
         $display("tb_running_median_two_heaps_core failed");
      end else begin
         $display("tb_running_median_two_heaps_core passed");
      end
      $finish;
   end

endmodule

`default_nettype wire
